/* design/gaussian_pyramid_reduce_unit_defines.svh */
// Assertion macros for the pyramid reduce unit.
// Needs a clock named clk and a reset named rst in the scope of each use.
`ifndef GAUSSIAN_PYRAMID_REDUCE_UNIT_DEFINES_SVH
`define GAUSSIAN_PYRAMID_REDUCE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define GPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpr assertion failed");

// next-cycle implication, checked in reset too
`define GPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gpr assertion failed");

`endif

/* design/gpr_pkg.sv */
// Types, constants and adder functions of the pyramid reduce unit.
// No dependencies.
package gpr_pkg;

  localparam int PIX_W      = 16;
  localparam int DIM_W      = 12;
  localparam int H_W        = 20;
  localparam int V_W        = 24;
  localparam int U_W        = 26;
  localparam int S_W        = 28;
  localparam int OCOL_W     = 10;
  localparam int OROW_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int RND_SHIFT  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [DIM_W-1:0] DIM_MIN      = 12'd4;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_THREE = 2'd2
  } vmode_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic [H_W-1:0]   hv;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] qbase;
    vmode_t           mode;
    logic             h_fill;
    logic             v_fill;
    logic             run_last;
    logic             defer;
  } job_t;

  function automatic logic [H_W-1:0] hsum5(input logic [PIX_W-1:0] a, b, c, d, e);
    return H_W'(a) + H_W'(e) + (H_W'(b) << 2) + (H_W'(d) << 2)
         + (H_W'(c) << 2) + (H_W'(c) << 1);
  endfunction

  function automatic logic [V_W-1:0] vsum5(input logic [H_W-1:0] a, b, c, d, e);
    return V_W'(a) + V_W'(e) + (V_W'(b) << 2) + (V_W'(d) << 2)
         + (V_W'(c) << 2) + (V_W'(c) << 1);
  endfunction

endpackage

/* design/gpr_in_if.sv */
// Pixel input channel: valid, ready and one UQ8.8 pixel.
// Depends on gpr_pkg.
interface gpr_in_if;
  logic                      valid;
  logic                      ready;
  logic [gpr_pkg::PIX_W-1:0] in_pixel;

  modport source (output valid, output in_pixel, input ready);
  modport sink   (input valid, input in_pixel, output ready);
endinterface

/* design/gpr_out_if.sv */
// Reduced pixel output channel: valid, ready and the result fields.
// Depends on gpr_pkg.
interface gpr_out_if;
  logic                       valid;
  logic                       ready;
  logic [gpr_pkg::PIX_W-1:0]  reduced_pixel;
  logic [gpr_pkg::OCOL_W-1:0] out_col;
  logic [gpr_pkg::OROW_W-1:0] out_row;
  logic                       run_end;
  logic                       frame_end;

  modport source (output valid, output reduced_pixel, output out_col, output out_row,
                  output run_end, output frame_end, input ready);
  modport sink   (input valid, input reduced_pixel, input out_col, input out_row,
                  input run_end, input frame_end, output ready);
endinterface

/* design/gpr_front.sv */
// Front end: pixel counters, row window and horizontal 5-tap blur; emits column jobs.
// Depends on gpr_pkg and gpr_in_if.
module gpr_front (
  input  logic           clk,
  input  logic           rst,
  gpr_in_if.sink         pix,
  input  gpr_pkg::dims_t dims,
  input  logic           restart,
  output logic           job_valid,
  input  logic           job_ready,
  output gpr_pkg::job_t  job
);
  import gpr_pkg::*;

  logic [DIM_W-1:0] col, row;
  logic [DIM_W-1:0] cc, rr, cn, rn;
  logic [PIX_W-1:0] win [5];
  logic [PIX_W-1:0] win_acc [5];
  logic [PIX_W-1:0] win_ext [5];
  logic [PIX_W-1:0] hold_p;
  logic [1:0]       extra;
  job_t             hold_job, job_acc, job_ext;
  logic             accept, wrap, row_end, last_row;
  logic [DIM_W-1:0] x0, xe;

  always_comb begin
    wrap     = (col >= dims.width) || (row >= dims.height);
    cc       = wrap ? '0 : col;
    rr       = wrap ? '0 : row;
    pix.ready = (extra == 2'd0) && job_ready;
    accept   = pix.valid && pix.ready;
    row_end  = (cc == dims.width - DIM_W'(1));
    last_row = (rr == dims.height - DIM_W'(1));
    for (int k = 0; k < 4; k++) begin
      win_acc[k] = (cc == '0) ? pix.in_pixel : win[k+1];
      win_ext[k] = win[k+1];
    end
    win_acc[4] = pix.in_pixel;
    win_ext[4] = hold_p;

    x0 = cc - DIM_W'(2);
    job_acc.hv       = hsum5(win_acc[0], win_acc[1], win_acc[2], win_acc[3], win_acc[4]);
    job_acc.x        = x0;
    job_acc.qbase    = rr - DIM_W'(2);
    job_acc.mode     = (rr < DIM_W'(2)) ? MODE_NONE : (last_row ? MODE_THREE : MODE_ONE);
    job_acc.h_fill   = (rr == '0);
    job_acc.v_fill   = (rr == DIM_W'(2));
    job_acc.run_last = x0[0] && !row_end;
    job_acc.defer    = last_row && row_end && x0[0] && !dims.height[0];

    xe = (extra == 2'd2) ? dims.width - DIM_W'(2) : dims.width - DIM_W'(1);
    job_ext          = hold_job;
    job_ext.hv       = hsum5(win_ext[0], win_ext[1], win_ext[2], win_ext[3], win_ext[4]);
    job_ext.x        = xe;
    job_ext.run_last = xe[0];
    job_ext.defer    = 1'b0;

    job_valid = (extra != 2'd0) || (accept && (cc >= DIM_W'(2)));
    job       = (extra != 2'd0) ? job_ext : job_acc;

    cn = cc + DIM_W'(1);
    rn = rr;
    if (cn >= dims.width) begin
      cn = '0;
      rn = (rr + DIM_W'(1) >= dims.height) ? '0 : rr + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col   <= '0;
      row   <= '0;
      extra <= 2'd0;
    end else if (accept) begin
      col   <= cn;
      row   <= rn;
      extra <= row_end ? 2'd2 : 2'd0;
    end else if ((extra != 2'd0) && job_ready) begin
      extra <= extra - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win      <= win_acc;
      hold_p   <= pix.in_pixel;
      hold_job <= job_acc;
    end else if ((extra != 2'd0) && job_ready) begin
      win <= win_ext;
    end
  end

endmodule

/* design/gpr_queue.sv */
// Short job queue between the front end and the back end.
// Depends on gpr_pkg.
module gpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gpr_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output gpr_pkg::job_t out_job
);
  import gpr_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  always_comb begin
    in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
    out_valid = (count != '0);
    out_job   = slots[rptr];
    push      = in_valid && in_ready;
    pop       = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_job;
  end

endmodule

/* design/gpr_back.sv */
// Back end: column line memory, vertical blur, 3x3 smoothing, decimation, output stage.
// Depends on gpr_pkg and gpr_out_if.
module gpr_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic           clk,
  input  logic           rst,
  input  gpr_pkg::dims_t dims,
  input  logic           job_valid,
  output logic           job_ready,
  input  gpr_pkg::job_t  job,
  gpr_out_if.source      res
);
  import gpr_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [3:0][H_W-1:0] h;
    logic [1:0][V_W-1:0] v;
  } line_t;

  typedef struct packed {
    logic [V_W-1:0]   v;
    logic [V_W-1:0]   vm2;
    logic [V_W-1:0]   vm1;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] q;
    logic [1:0]       d;
    logic             run_end;
    logic             defer;
  } s2_t;

  typedef struct packed {
    logic [U_W-1:0]   u;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] q;
    logic [1:0]       d;
    logic             run_end;
    logic             defer;
  } s3_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              run_end;
    logic              frame_end;
  } result_t;

  line_t lines [MAX_WIDTH];
  line_t rd, wword;

  logic                s1_valid, s2_valid, s3_valid, ov, dv;
  job_t                s1_job;
  logic [1:0]          s1_d, d_last;
  logic [1:0][V_W-1:0] vloc, vcur, vnext;
  logic [6:0][H_W-1:0] t;
  logic [V_W-1:0]      vval;
  s2_t                 s2, s2_next;
  s3_t                 s3;
  logic [U_W-1:0]      uw0 [3];
  logic [U_W-1:0]      uw1 [3];
  logic [S_W-1:0]      sum;
  result_t             cur, out_q, defer_q;
  logic                en, adv, flush, s1_last, s1_fin, pop, s3_res;

  always_comb begin
    en      = !ov || res.ready;
    s3_res  = s3_valid && s3.q[0] && s3.x[0];
    flush   = s3_res && (s3.d == 2'd2) && !s3.defer && dv;
    adv     = en && !flush;
    d_last  = (s1_job.mode == MODE_THREE) ? 2'd2 : 2'd0;
    s1_last = (s1_d == d_last);
    s1_fin  = s1_valid && s1_last;
    job_ready = adv && (!s1_valid || s1_last);
    pop     = job_valid && job_ready;

    for (int k = 0; k < 4; k++) t[k] = rd.h[k];
    for (int k = 4; k < 7; k++) t[k] = s1_job.hv;
    case (s1_d)
      2'd0:    vval = vsum5(t[0], t[1], t[2], t[3], t[4]);
      2'd1:    vval = vsum5(t[1], t[2], t[3], t[4], t[5]);
      default: vval = vsum5(t[2], t[3], t[4], t[5], t[6]);
    endcase
    vcur  = (s1_d == 2'd0) ? rd.v : vloc;
    vnext = (s1_job.v_fill && (s1_d == 2'd0)) ? {vval, vval} : {vval, vcur[1]};

    wword.h = s1_job.h_fill ? {4{s1_job.hv}} : {s1_job.hv, rd.h[3], rd.h[2], rd.h[1]};
    wword.v = (s1_job.mode == MODE_NONE) ? rd.v : vnext;

    s2_next.v       = vval;
    s2_next.vm2     = vcur[0];
    s2_next.vm1     = vcur[1];
    s2_next.x       = s1_job.x;
    s2_next.q       = s1_job.qbase + DIM_W'(s1_d);
    s2_next.d       = s1_d;
    s2_next.run_end = s1_job.run_last && ((s1_job.mode == MODE_ONE) || (s1_d != 2'd0));
    s2_next.defer   = s1_job.defer && (s1_d == 2'd2);

    sum = S_W'(uw0[s3.d]) + (S_W'(uw1[s3.d]) << 1) + S_W'(s3.u);
    cur.pixel     = PIX_W'((sum + S_W'(1 << (RND_SHIFT - 1))) >> RND_SHIFT);
    cur.col       = OCOL_W'(s3.x >> 1);
    cur.row       = OROW_W'(s3.q >> 1);
    cur.run_end   = s3.run_end;
    cur.frame_end = (s3.x >= dims.width - DIM_W'(2)) && (s3.q >= dims.height - DIM_W'(2));
  end

  always_ff @(posedge clk) begin
    if (pop) rd <= lines[AW'(job.x)];
    if (adv && s1_fin) lines[AW'(s1_job.x)] <= wword;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s1_d     <= 2'd0;
    end else if (adv) begin
      if (pop) begin
        s1_valid <= 1'b1;
        s1_d     <= 2'd0;
      end else if (s1_fin) begin
        s1_valid <= 1'b0;
      end else if (s1_valid) begin
        s1_d <= s1_d + 2'd1;
      end
      s2_valid <= s1_valid && (s1_job.mode != MODE_NONE);
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      dv <= 1'b0;
    end else if (en) begin
      if (flush) begin
        ov <= 1'b1;
        dv <= 1'b0;
      end else if (s3_res && s3.defer) begin
        ov <= 1'b0;
        dv <= 1'b1;
      end else begin
        ov <= s3_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1_job <= job;
    if (adv && s1_valid) vloc <= vnext;
    if (adv) begin
      s2    <= s2_next;
      s3.u  <= U_W'(s2.vm2) + (U_W'(s2.vm1) << 1) + U_W'(s2.v);
      s3.x  <= s2.x;
      s3.q  <= s2.q;
      s3.d  <= s2.d;
      s3.run_end <= s2.run_end;
      s3.defer   <= s2.defer;
    end
    if (adv && s3_valid) begin
      uw0[s3.d] <= (s3.x == '0) ? s3.u : uw1[s3.d];
      uw1[s3.d] <= s3.u;
    end
    if (en) begin
      if (flush) out_q <= defer_q;
      else if (s3_res && !s3.defer) out_q <= cur;
      if (!flush && s3_res && s3.defer) defer_q <= cur;
    end
  end

  assign res.valid         = ov;
  assign res.reduced_pixel = out_q.pixel;
  assign res.out_col       = out_q.col;
  assign res.out_row       = out_q.row;
  assign res.run_end       = out_q.run_end;
  assign res.frame_end     = out_q.frame_end;

endmodule

/* design/gaussian_pyramid_reduce_unit.sv */
// Channel | Direction | Handshake   | Payload
// pix     | in        | valid/ready | in_pixel (UQ8.8)
// res     | out       | valid/ready | reduced_pixel, out_col, out_row, run_end, frame_end
// cfg     | in        | write_en    | reg_index, write_data
//
// One pixel per cycle inside a row while the job queue has room; the last
// pixel of a row yields three column jobs. On the last input row each column
// job runs the vertical blur three times. The back-end column memory (one
// read-modify-write per job) sets the pace. Reset is synchronous; a write to
// the width or height register restarts the frame. Results sit in an output
// register, and the job queue lets the front keep taking pixels while it waits.
// Depends on gpr_pkg, the channel interfaces, gpr_front, gpr_queue and gpr_back.
module gaussian_pyramid_reduce_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  gpr_in_if.sink                             pix,
  gpr_out_if.source                          res,
  input  logic                               write_en,
  input  logic [gpr_pkg::CFG_IDX_W-1:0]      reg_index,
  input  logic [gpr_pkg::CFG_DATA_W-1:0]     write_data
);
  import gpr_pkg::*;

  `include "gaussian_pyramid_reduce_unit_defines.svh"

  logic [DIM_W-1:0] image_width, image_height;
  dims_t            dims;
  logic             restart;
  logic             f2q_valid, f2q_ready, q2b_valid, q2b_ready;
  job_t             f2q_job, q2b_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_WIDTH:  image_width  <= write_data;
        REG_HEIGHT: image_height <= write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = write_en && ((reg_index == REG_WIDTH) || (reg_index == REG_HEIGHT));
    if (image_width < DIM_MIN)                dims.width = DIM_MIN;
    else if (int'(image_width) > MAX_WIDTH)   dims.width = DIM_W'(MAX_WIDTH);
    else                                      dims.width = image_width;
    dims.height = (image_height < DIM_MIN) ? DIM_MIN : image_height;
  end

  gpr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .dims      (dims),
    .restart   (restart),
    .job_valid (f2q_valid),
    .job_ready (f2q_ready),
    .job       (f2q_job)
  );

  gpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f2q_valid),
    .in_ready  (f2q_ready),
    .in_job    (f2q_job),
    .out_valid (q2b_valid),
    .out_ready (q2b_ready),
    .out_job   (q2b_job)
  );

  gpr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .job_valid (q2b_valid),
    .job_ready (q2b_ready),
    .job       (q2b_job),
    .res       (res)
  );

  `GPR_ASSERT_IMP(a_full_queue_holds_input, f2q_valid && !f2q_ready, !pix.ready)
  `GPR_ASSERT_IMP(a_frame_end_ends_run, res.valid && res.frame_end, res.run_end)
  `GPR_ASSERT_NEXT(a_reset_clears_output, rst, !res.valid)

endmodule
